>>> rtl/cnm_pkg.sv
// ---------------------------------------------------------------------------
// Cross neighbourhood mean filter package
// Shared widths, register indexes, the result record and the mean divider.
// ---------------------------------------------------------------------------
`default_nettype none

package cnm_pkg;

   localparam int PIXEL_W          = 8;
   localparam int CFG_W            = 11;
   localparam int CSR_IDX_W        = 2;
   localparam int SUM_W            = 11;
   localparam int CNT_W            = 3;
   localparam int OUT_COL_W        = 10;
   localparam int OUT_ROW_W        = 10;
   localparam int NUM_SLOTS        = 3;

   localparam int DEF_MAX_WIDTH    = 1024;
   localparam int DEF_MAX_HEIGHT   = 1024;
   localparam int RST_FRAME_WIDTH  = 640;
   localparam int RST_FRAME_HEIGHT = 480;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
   localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;
   localparam logic [CNT_W-1:0] CNT_FIVE  = 3'd5;

   localparam int DIV_SHIFT   = 13;
   localparam int PROD_W      = SUM_W + DIV_SHIFT;
   localparam int RECIP_THREE = 2731;
   localparam int RECIP_FIVE  = 1639;

   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [CNT_W-1:0]     cnt;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic                 done;
   } cnm_result_type;

   // Floor of sum / cnt for a count of three, four or five, by reciprocal
   // multiplication; exact for every sum below 2048.
   function automatic logic [PIXEL_W-1:0] cnm_mean(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] cnt);
      logic [PROD_W-1:0] prod;
      prod = '0;
      unique case (cnt)
         CNT_THREE: prod = PROD_W'(sum) * PROD_W'(RECIP_THREE);
         CNT_FOUR:  prod = PROD_W'(sum) << (DIV_SHIFT - 2);
         CNT_FIVE:  prod = PROD_W'(sum) * PROD_W'(RECIP_FIVE);
         default:   prod = '0;
      endcase
      return PIXEL_W'(prod >> DIV_SHIFT);
   endfunction

endpackage

`default_nettype wire

>>> rtl/cross_neighbourhood_mean_filter.sv
// ---------------------------------------------------------------------------
// Cross neighbourhood mean filter
// Floor mean of each pixel and its in-frame left, right, upper and lower
// neighbours over a raster stream, using two row banks of line store.
// Results raised by a pixel wait in the result queue and pass through the
// divider into the output register. Throughput: one pixel per cycle while
// the output does not stall, on all rows but the last; there each pixel
// after the first raises two results, the final pixel three, and the next
// pixel waits while the single output register drains the queue. Reset:
// counters and previous pixels clear, the frame returns to 640 x 480,
// no pixel is taken until data_ok_ff sets; the line store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module cross_neighbourhood_mean_filter
   import cnm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIXEL_W-1:0]   req_pixel,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [PIXEL_W-1:0]   rsp_mean_value,
   output logic      [OUT_COL_W-1:0] rsp_out_column,
   output logic      [OUT_ROW_W-1:0] rsp_out_row,
   output logic                      rsp_frame_done,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WD_W   = COL_W + 1;
   localparam int HD_W   = ROW_W + 1;
   localparam int CMPW_W = (CFG_W > WD_W) ? CFG_W : WD_W;
   localparam int CMPH_W = (CFG_W > HD_W) ? CFG_W : HD_W;
   localparam int W_RESET = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
   localparam int H_RESET = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

   logic [WD_W-1:0]    width_ff, width_in;
   logic [HD_W-1:0]    height_ff, height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PIXEL_W-1:0] prev_ff, prev_in;
   logic [PIXEL_W-1:0] prev2_ff, prev2_in;
   logic [PIXEL_W-1:0] left_ff, left_in;
   logic               data_ok_ff;

   logic [CMPW_W-1:0]  wr_w;
   logic [CMPH_W-1:0]  wr_h;
   logic               wr_width, wr_height, restart;
   logic               accept, can_push;
   logic               last_col, last_row;
   logic               c_gt0, c_ge2, r_gt0, r_ge2;
   logic [PIXEL_W-1:0] above_mid, above_right, up_two;

   logic [NUM_SLOTS-1:0]           push_mask;
   cnm_result_type [NUM_SLOTS-1:0] push_rec;

   assign csr_ready = 1'b1;
   assign wr_width  = csr_valid && csr_ready && (csr_index == REG_FRAME_WIDTH);
   assign wr_height = csr_valid && csr_ready && (csr_index == REG_FRAME_HEIGHT);
   assign restart   = wr_width || wr_height;

   assign req_stall = !(data_ok_ff && can_push);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      wr_w = CMPW_W'(csr_data);
      wr_h = CMPH_W'(csr_data);
      if (wr_w < CMPW_W'(2)) begin
         width_in = WD_W'(2);
      end else if (wr_w > CMPW_W'(MAX_WIDTH)) begin
         width_in = WD_W'(MAX_WIDTH);
      end else begin
         width_in = WD_W'(wr_w);
      end
      if (wr_h < CMPH_W'(2)) begin
         height_in = HD_W'(2);
      end else if (wr_h > CMPH_W'(MAX_HEIGHT)) begin
         height_in = HD_W'(MAX_HEIGHT);
      end else begin
         height_in = HD_W'(wr_h);
      end
   end

   always_comb begin
      last_col = ((WD_W'(col_ff) + WD_W'(1)) == width_ff);
      last_row = ((HD_W'(row_ff) + HD_W'(1)) == height_ff);
      c_gt0    = (col_ff != '0);
      c_ge2    = c_gt0 && (col_ff != COL_W'(1));
      r_gt0    = (row_ff != '0);
      r_ge2    = r_gt0 && (row_ff != ROW_W'(1));
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      left_in  = left_ff;
      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         prev_in  = '0;
         prev2_in = '0;
      end else if (accept) begin
         prev_in  = req_pixel;
         prev2_in = prev_ff;
         left_in  = above_mid;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WD_W'(W_RESET);
         height_ff  <= HD_W'(H_RESET);
         col_ff     <= '0;
         row_ff     <= '0;
         prev_ff    <= '0;
         prev2_ff   <= '0;
         data_ok_ff <= 1'b0;
      end else begin
         if (wr_width) begin
            width_ff <= width_in;
         end
         if (wr_height) begin
            height_ff <= height_in;
         end
         col_ff     <= col_in;
         row_ff     <= row_in;
         prev_ff    <= prev_in;
         prev2_ff   <= prev2_in;
         data_ok_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   cnm_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock       (clock),
      .wr_en       (accept),
      .wr_par      (row_ff[0]),
      .wr_col      (col_ff),
      .wr_data     (req_pixel),
      .rd_par      (row_in[0]),
      .rd_col      (col_in),
      .above_mid   (above_mid),
      .above_right (above_right),
      .up_two      (up_two)
   );

   always_comb begin
      push_mask = {last_row && last_col, last_row && c_gt0, r_gt0};

      push_rec[0].sum  = SUM_W'(above_mid) + SUM_W'(req_pixel)
                       + (c_gt0 ? SUM_W'(left_ff) : '0)
                       + (!last_col ? SUM_W'(above_right) : '0)
                       + (r_ge2 ? SUM_W'(up_two) : '0);
      push_rec[0].cnt  = CNT_W'(2) + CNT_W'(c_gt0) + CNT_W'(!last_col) + CNT_W'(r_ge2);
      push_rec[0].col  = OUT_COL_W'(col_ff);
      push_rec[0].row  = OUT_ROW_W'(row_ff - ROW_W'(1));
      push_rec[0].done = 1'b0;

      push_rec[1].sum  = SUM_W'(prev_ff) + SUM_W'(req_pixel)
                       + (c_ge2 ? SUM_W'(prev2_ff) : '0)
                       + (r_gt0 ? SUM_W'(left_ff) : '0);
      push_rec[1].cnt  = CNT_W'(2) + CNT_W'(c_ge2) + CNT_W'(r_gt0);
      push_rec[1].col  = OUT_COL_W'(col_ff - COL_W'(1));
      push_rec[1].row  = OUT_ROW_W'(row_ff);
      push_rec[1].done = 1'b0;

      push_rec[2].sum  = SUM_W'(req_pixel)
                       + (c_gt0 ? SUM_W'(prev_ff) : '0)
                       + (r_gt0 ? SUM_W'(above_mid) : '0);
      push_rec[2].cnt  = CNT_W'(1) + CNT_W'(c_gt0) + CNT_W'(r_gt0);
      push_rec[2].col  = OUT_COL_W'(col_ff);
      push_rec[2].row  = OUT_ROW_W'(row_ff);
      push_rec[2].done = 1'b1;
   end

   cnm_out_queue u_out_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (accept),
      .push_mask      (push_mask),
      .push_rec       (push_rec),
      .can_push       (can_push),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done)
   );

   a_col_in_frame : assert property (@(posedge clock) disable iff (reset)
      WD_W'(col_ff) < width_ff)
      else $error("column counter beyond frame width");

   a_row_in_frame : assert property (@(posedge clock) disable iff (reset)
      HD_W'(row_ff) < height_ff)
      else $error("row counter beyond frame height");

   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && last_col && last_row) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not return to the frame origin");

   a_no_accept_before_data : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !accept)
      else $error("pixel taken before the line store read was valid");

endmodule

`default_nettype wire

>>> rtl/cnm_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> rtl/cnm_line_store.sv
// ---------------------------------------------------------------------------
// Line store
// Two row banks selected by row parity. Both banks are read at the column
// of the next pixel and at the column to its right; a write that lands on
// an address being read in the same cycle is forwarded.
// ---------------------------------------------------------------------------
`default_nettype none

module cnm_line_store
   import cnm_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic                         wr_par,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_col,
   input  wire logic [PIXEL_W-1:0]           wr_data,
   input  wire logic                         rd_par,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_col,
   output logic      [PIXEL_W-1:0]           above_mid,
   output logic      [PIXEL_W-1:0]           above_right,
   output logic      [PIXEL_W-1:0]           up_two
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [COL_W-1:0]   rd_col_right;
   logic [PIXEL_W-1:0] bank0_a, bank0_b, bank1_a, bank1_b;
   logic [PIXEL_W-1:0] fix0_a, fix0_b, fix1_a, fix1_b;
   logic               sel_par_ff;
   logic               fwd_a_ff;
   logic               fwd_b_ff;
   logic               fwd_par_ff;
   logic [PIXEL_W-1:0] fwd_data_ff;

   assign rd_col_right = rd_col + COL_W'(1);

   cnm_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_bank0 (
      .clock     (clock),
      .wr_en     (wr_en && !wr_par),
      .wr_addr   (wr_col),
      .wr_data   (wr_data),
      .rd_addr_a (rd_col),
      .rd_data_a (bank0_a),
      .rd_addr_b (rd_col_right),
      .rd_data_b (bank0_b)
   );

   cnm_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_bank1 (
      .clock     (clock),
      .wr_en     (wr_en && wr_par),
      .wr_addr   (wr_col),
      .wr_data   (wr_data),
      .rd_addr_a (rd_col),
      .rd_data_a (bank1_a),
      .rd_addr_b (rd_col_right),
      .rd_data_b (bank1_b)
   );

   always_ff @(posedge clock) begin
      sel_par_ff  <= rd_par;
      fwd_a_ff    <= wr_en && (wr_col == rd_col);
      fwd_b_ff    <= wr_en && (wr_col == rd_col_right);
      fwd_par_ff  <= wr_par;
      fwd_data_ff <= wr_data;
   end

   always_comb begin
      fix0_a = (fwd_a_ff && !fwd_par_ff) ? fwd_data_ff : bank0_a;
      fix0_b = (fwd_b_ff && !fwd_par_ff) ? fwd_data_ff : bank0_b;
      fix1_a = (fwd_a_ff &&  fwd_par_ff) ? fwd_data_ff : bank1_a;
      fix1_b = (fwd_b_ff &&  fwd_par_ff) ? fwd_data_ff : bank1_b;
   end

   // The bank of the current row holds the row two above; the other bank
   // holds the row directly above.
   assign above_mid   = sel_par_ff ? fix0_a : fix1_a;
   assign above_right = sel_par_ff ? fix0_b : fix1_b;
   assign up_two      = sel_par_ff ? fix1_a : fix0_a;

endmodule

`default_nettype wire

>>> rtl/cnm_out_queue.sv
// ---------------------------------------------------------------------------
// Result queue
// Holds the up to three results raised by one pixel and hands them one at a
// time, in order, through the divider into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cnm_out_queue
   import cnm_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire logic [NUM_SLOTS-1:0]                 push_mask,
   input  wire cnm_result_type [NUM_SLOTS-1:0]       push_rec,
   output logic                                      can_push,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [PIXEL_W-1:0]                   rsp_mean_value,
   output logic      [OUT_COL_W-1:0]                 rsp_out_column,
   output logic      [OUT_ROW_W-1:0]                 rsp_out_row,
   output logic                                      rsp_frame_done
);

   logic [NUM_SLOTS-1:0]       pend_ff, pend_in, pend_after, sel_hot;
   cnm_result_type [NUM_SLOTS-1:0] slot_ff;
   cnm_result_type             head;
   logic                       valid_ff, valid_in;
   logic                       load_out;
   logic                       move;
   logic [PIXEL_W-1:0]         mean_ff;
   logic [OUT_COL_W-1:0]       col_ff;
   logic [OUT_ROW_W-1:0]       row_ff;
   logic                       done_ff;

   always_comb begin
      sel_hot = pend_ff & ~(pend_ff - NUM_SLOTS'(1));
      head    = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (sel_hot[i]) begin
            head = slot_ff[i];
         end
      end
      load_out   = !valid_ff || !rsp_stall;
      move       = load_out && (pend_ff != '0);
      pend_after = move ? (pend_ff & ~sel_hot) : pend_ff;
      can_push   = (pend_after == '0);
      pend_in    = push ? push_mask : pend_after;
      valid_in   = move ? 1'b1 : (load_out ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff <= push_rec;
      end
      if (move) begin
         mean_ff <= cnm_mean(head.sum, head.cnt);
         col_ff  <= head.col;
         row_ff  <= head.row;
         done_ff <= head.done;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_mean_value = mean_ff;
   assign rsp_out_column = col_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_frame_done = done_ff;

endmodule

`default_nettype wire
